### rtl/rmth_pkg.sv
// Shared constants, codes and types for the running median block.
package rmth_pkg;

    localparam int Capacity   = 1024;
    localparam int ValueWidth = 32;
    localparam int LowerDepth = Capacity / 2;
    localparam int UpperDepth = (Capacity + 1) / 2;
    localparam int AddrWidth  = $clog2(UpperDepth);
    localparam int HeapCountWidth = $clog2(UpperDepth + 1);
    localparam int CountWidth = 11;

    localparam logic [1:0] FUNC_PUSH  = 2'd0;
    localparam logic [1:0] FUNC_POP   = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_POP_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_PUSH_FULL = 2'd2;

    typedef logic signed [ValueWidth-1:0] value_t;
    typedef logic [AddrWidth-1:0] addr_t;
    typedef logic [HeapCountWidth-1:0] hcount_t;

    // Datapath operation codes.
    localparam logic [2:0] DOP_NONE     = 3'd0;
    localparam logic [2:0] DOP_INSERT   = 3'd1; // place x at index count, sift up
    localparam logic [2:0] DOP_REMOVE   = 3'd2; // move last to top, sift down
    localparam logic [2:0] DOP_REPLACE  = 3'd3; // put x at top, sift down

    // Controller to datapath command.
    typedef struct packed {
        logic       go;
        logic [2:0] op;
        logic       upper;   // 1: min-heap, 0: max-heap
        value_t     x;
        logic       clear;
    } dp_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic    done;
        value_t  lower_top;
        value_t  upper_top;
        hcount_t lower_count;
        hcount_t upper_count;
    } dp_stat_t;

endpackage

### rtl/rmth_heap_dp.sv
// Heap datapath: two heap memories, counts, cached tops and a sift engine.
module rmth_heap_dp
(
    input  logic               clk,
    input  logic               rst_n,
    input  rmth_pkg::dp_cmd_t  cmd,
    output rmth_pkg::dp_stat_t stat
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_UPRD  = 4'd1;  // read parent
    localparam logic [3:0] S_UPCMP = 4'd2;  // compare with parent
    localparam logic [3:0] S_RDLST = 4'd3;  // read last entry
    localparam logic [3:0] S_LSTW  = 4'd4;  // last entry data valid
    localparam logic [3:0] S_DNRDL = 4'd5;  // read left child
    localparam logic [3:0] S_DNRDR = 4'd6;  // read right child, left data valid
    localparam logic [3:0] S_DNCMP = 4'd8;  // right data valid, decide
    localparam logic [3:0] S_DONE  = 4'd9;

    logic signed [rmth_pkg::ValueWidth-1:0] lower_mem [rmth_pkg::LowerDepth];
    logic signed [rmth_pkg::ValueWidth-1:0] upper_mem [rmth_pkg::UpperDepth];

    logic [3:0]       state_reg, state_next;
    logic             upper_reg;
    rmth_pkg::value_t cur_reg;       // value being sifted
    rmth_pkg::addr_t  idx_reg;       // its position
    rmth_pkg::hcount_t n_reg;        // heap size during sift down
    rmth_pkg::value_t left_reg;
    rmth_pkg::hcount_t lower_count_reg, upper_count_reg;
    rmth_pkg::value_t lower_top_reg, upper_top_reg;

    // Single memory port, shared by reads and writes
    logic             we;
    rmth_pkg::addr_t  addr;
    rmth_pkg::value_t wdata;
    rmth_pkg::value_t rdata;

    always_ff @(posedge clk)
    begin
        if (upper_reg)
        begin
            if (we) upper_mem[addr] <= wdata;
            rdata <= upper_mem[addr];
        end
        else
        begin
            if (we) lower_mem[addr] <= wdata;
            rdata <= lower_mem[addr];
        end
    end

    function automatic logic above(input rmth_pkg::value_t a, input rmth_pkg::value_t b,
                                   input logic is_min);
        above = is_min ? (a < b) : (a > b);
    endfunction

    rmth_pkg::addr_t parent, lidx, ridx;
    logic [rmth_pkg::AddrWidth+1:0] l_wide;
    assign parent = (idx_reg - 1'b1) >> 1;
    assign l_wide = {1'b0, idx_reg, 1'b1};
    assign lidx   = l_wide[rmth_pkg::AddrWidth-1:0];
    assign ridx   = lidx + 1'b1;

    logic l_in, r_in;
    assign l_in = l_wide < {1'b0, n_reg};
    assign r_in = (l_wide + 1'b1) < {1'b0, n_reg};

    rmth_pkg::hcount_t cnt_sel;
    assign cnt_sel = cmd.upper ? upper_count_reg : lower_count_reg;

    // Sift control
    logic             top_we;
    rmth_pkg::value_t top_val;
    logic             best_is_l;
    rmth_pkg::value_t best_val;

    always_comb
    begin
        state_next = state_reg;
        we = 1'b0;
        addr = idx_reg;
        wdata = cur_reg;
        top_we = 1'b0;
        top_val = cur_reg;
        best_is_l = 1'b1;
        best_val = left_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.go)
                    state_next = (cmd.op == rmth_pkg::DOP_INSERT) ? S_UPRD :
                                 (cmd.op == rmth_pkg::DOP_REMOVE) ? S_RDLST : S_DNRDL;
            end
            S_UPRD:
            begin
                if (idx_reg == '0)
                begin
                    we = 1'b1;
                    top_we = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    addr = parent;
                    state_next = S_UPCMP;
                end
            end
            S_UPCMP:
            begin
                if (above(cur_reg, rdata, upper_reg))
                begin
                    we = 1'b1;
                    wdata = rdata;   // parent moves down
                    state_next = S_UPRD;
                end
                else
                begin
                    we = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_RDLST:
            begin
                addr = n_reg[rmth_pkg::AddrWidth-1:0];
                state_next = S_LSTW;
            end
            S_LSTW:
            begin
                state_next = S_DNRDL;
            end
            S_DNRDL:
            begin
                if (!l_in)
                begin
                    we = 1'b1;
                    if (idx_reg == '0) top_we = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    addr = lidx;
                    state_next = S_DNRDR;
                end
            end
            S_DNRDR:
            begin
                addr = ridx;
                state_next = S_DNCMP;
            end
            S_DNCMP:
            begin
                if (r_in && above(rdata, left_reg, upper_reg))
                begin
                    best_is_l = 1'b0;
                    best_val = rdata;
                end
                if (above(best_val, cur_reg, upper_reg))
                begin
                    we = 1'b1;
                    wdata = best_val;
                    if (idx_reg == '0)
                    begin
                        top_we = 1'b1;
                        top_val = best_val;
                    end
                    state_next = S_DNRDL;
                end
                else
                begin
                    we = 1'b1;
                    if (idx_reg == '0) top_we = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (state_reg == S_UPCMP && !above(cur_reg, rdata, upper_reg) && idx_reg == '0)
            top_we = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            lower_count_reg <= '0;
            upper_count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.clear)
            begin
                lower_count_reg <= '0;
                upper_count_reg <= '0;
            end
            else if (cmd.go && state_reg == S_IDLE)
            begin
                if (cmd.op == rmth_pkg::DOP_INSERT)
                begin
                    if (cmd.upper) upper_count_reg <= upper_count_reg + 1'b1;
                    else           lower_count_reg <= lower_count_reg + 1'b1;
                end
                else if (cmd.op == rmth_pkg::DOP_REMOVE)
                begin
                    if (cmd.upper) upper_count_reg <= upper_count_reg - 1'b1;
                    else           lower_count_reg <= lower_count_reg - 1'b1;
                end
            end
        end
    end

    // Sift registers
    always_ff @(posedge clk)
    begin
        if (cmd.go && state_reg == S_IDLE)
        begin
            upper_reg <= cmd.upper;
            cur_reg   <= cmd.x;
            if (cmd.op == rmth_pkg::DOP_INSERT)
            begin
                idx_reg <= cnt_sel[rmth_pkg::AddrWidth-1:0];
            end
            else if (cmd.op == rmth_pkg::DOP_REMOVE)
            begin
                idx_reg <= '0;
                n_reg   <= cnt_sel - 1'b1;
            end
            else
            begin
                idx_reg <= '0;
                n_reg   <= cnt_sel;
            end
        end
        else
        begin
            case (state_reg)
                S_UPCMP:
                    if (above(cur_reg, rdata, upper_reg)) idx_reg <= parent;
                S_LSTW:
                    cur_reg <= rdata;
                S_DNRDR:
                    left_reg <= rdata;
                S_DNCMP:
                    if (above(best_val, cur_reg, upper_reg))
                        idx_reg <= best_is_l ? lidx : ridx;
                default:
                begin
                end
            endcase
        end
        if (top_we)
        begin
            if (upper_reg) upper_top_reg <= top_val;
            else           lower_top_reg <= top_val;
        end
    end

    assign stat.done        = (state_reg == S_DONE);
    assign stat.lower_top   = lower_top_reg;
    assign stat.upper_top   = upper_top_reg;
    assign stat.lower_count = lower_count_reg;
    assign stat.upper_count = upper_count_reg;

endmodule

### rtl/rmth_ctrl.sv
// Controller: decodes the operation and sequences heap steps.
module rmth_ctrl
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [1:0]                  func,
    input  logic signed [31:0]          value,
    output logic                        busy,
    output logic                        done,
    output logic signed [31:0]          lower_median,
    output logic signed [32:0]          median_times_two,
    output logic [10:0]                 item_count,
    output logic                        is_empty,
    output logic [1:0]                  status,
    output rmth_pkg::dp_cmd_t           cmd,
    input  rmth_pkg::dp_stat_t          stat
);

    localparam logic [2:0] C_IDLE  = 3'd0;
    localparam logic [2:0] C_STEP1 = 3'd1;  // first heap step running
    localparam logic [2:0] C_ISSUE2 = 3'd2;
    localparam logic [2:0] C_STEP2 = 3'd3;
    localparam logic [2:0] C_REPORT = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [2:0]       op2_reg;
    logic             up2_reg;
    rmth_pkg::value_t x2_reg;
    logic [1:0]       status_reg;
    logic             done_reg;
    rmth_pkg::value_t lmed_reg;
    logic signed [32:0] twice_reg;
    logic [10:0]      count_reg;

    rmth_pkg::value_t lt, ut;
    rmth_pkg::hcount_t lc, uc;
    logic [10:0] total;
    assign lt = stat.lower_top;
    assign ut = stat.upper_top;
    assign lc = stat.lower_count;
    assign uc = stat.upper_count;
    assign total = 11'(lc) + 11'(uc);

    // Decode of the accepted beat into up to two heap operations
    logic [2:0] op1, op2;
    logic       up1, up2;
    rmth_pkg::value_t x1, x2;
    logic [1:0] st;
    always_comb
    begin
        op1 = rmth_pkg::DOP_NONE; op2 = rmth_pkg::DOP_NONE;
        up1 = 1'b1; up2 = 1'b0; x1 = value; x2 = value;
        st = rmth_pkg::STATUS_OK;
        case (func)
            rmth_pkg::FUNC_PUSH:
            begin
                if (total >= 11'(rmth_pkg::Capacity))
                    st = rmth_pkg::STATUS_PUSH_FULL;
                else if (uc == '0 || value >= ut)
                begin
                    if (uc == lc)
                        op1 = rmth_pkg::DOP_INSERT;
                    else
                    begin
                        op1 = rmth_pkg::DOP_REPLACE;
                        op2 = rmth_pkg::DOP_INSERT; up2 = 1'b0; x2 = ut;
                    end
                end
                else if (uc == lc)
                begin
                    if (lc == '0 || value >= lt)
                        op1 = rmth_pkg::DOP_INSERT;
                    else
                    begin
                        op1 = rmth_pkg::DOP_REPLACE; up1 = 1'b0;
                        op2 = rmth_pkg::DOP_INSERT; up2 = 1'b1; x2 = lt;
                    end
                end
                else
                begin
                    op1 = rmth_pkg::DOP_INSERT; up1 = 1'b0;
                end
            end
            rmth_pkg::FUNC_POP:
            begin
                if (total == '0) st = rmth_pkg::STATUS_POP_EMPTY;
                else
                begin
                    op1 = rmth_pkg::DOP_REMOVE;
                    up1 = (lc != uc);
                end
            end
            default:
            begin
            end
        endcase
    end

    logic accept;
    assign accept = start && !busy;

    always_comb
    begin
        state_next = state_reg;
        cmd.go = 1'b0; cmd.op = op1; cmd.upper = up1; cmd.x = x1;
        cmd.clear = accept && (func == rmth_pkg::FUNC_CLEAR);
        case (state_reg)
            C_IDLE:
                if (accept)
                begin
                    if (op1 != rmth_pkg::DOP_NONE)
                    begin
                        cmd.go = 1'b1;
                        state_next = C_STEP1;
                    end
                    else
                        state_next = C_REPORT;
                end
            C_STEP1:
                if (stat.done)
                    state_next = (op2_reg != rmth_pkg::DOP_NONE) ? C_ISSUE2 : C_REPORT;
            C_ISSUE2:
            begin
                cmd.go = 1'b1; cmd.op = op2_reg; cmd.upper = up2_reg; cmd.x = x2_reg;
                state_next = C_STEP2;
            end
            C_STEP2:
                if (stat.done) state_next = C_REPORT;
            C_REPORT:
                state_next = C_IDLE;
            default:
                state_next = C_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == C_REPORT);
        end
    end

    // Latch the second step and status on accept; register the result beat in the report state after the heaps settle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op2_reg <= op2; up2_reg <= up2; x2_reg <= x2; status_reg <= st;
        end
        if (state_reg == C_REPORT)
        begin
            count_reg <= total;
            if (total == '0)
            begin
                lmed_reg <= '0; twice_reg <= '0;
            end
            else if (lc == uc)
            begin
                lmed_reg  <= lt;
                twice_reg <= 33'(lt) + 33'(ut);
            end
            else
            begin
                lmed_reg  <= ut;
                twice_reg <= 33'(ut) + 33'(ut);
            end
        end
    end

    assign busy = (state_reg != C_IDLE) || done_reg;
    assign done = done_reg;
    assign lower_median = lmed_reg;
    assign median_times_two = twice_reg;
    assign item_count = count_reg;
    assign is_empty = (count_reg == '0);
    assign status = status_reg;

endmodule

### rtl/running_median_two_heaps_top.sv
// Top level of the running median block: controller plus heap datapath.
// One beat at a time: start is taken while busy is low; the result beat
// shows on the result ports with done high for one cycle, and cannot be
// stalled. A push walks at most two heap sifts over up to nine levels on
// the single memory port: each level sifting down reads the left child,
// reads the right child and then decides; each level sifting up reads
// the parent and then compares.
module running_median_two_heaps_top
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [1:0]         func,
    input  logic signed [31:0] value,
    output logic               busy,
    output logic               done,
    output logic signed [31:0] lower_median,
    output logic signed [32:0] median_times_two,
    output logic [10:0]        item_count,
    output logic               is_empty,
    output logic [1:0]         status
);

    rmth_pkg::dp_cmd_t  cmd;
    rmth_pkg::dp_stat_t stat;

    rmth_ctrl u_ctrl
    (
        .clk(clk), .rst_n(rst_n), .start(start), .func(func), .value(value),
        .busy(busy), .done(done), .lower_median(lower_median),
        .median_times_two(median_times_two), .item_count(item_count),
        .is_empty(is_empty), .status(status), .cmd(cmd), .stat(stat)
    );

    rmth_heap_dp u_dp
    (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat)
    );

`ifndef ASSERT_OFF
    // Heaps stay balanced: upper holds as many or one more
    a_balance: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> (stat.upper_count == stat.lower_count ||
                   stat.upper_count == stat.lower_count + 1'b1))
        else $error("heap sizes out of balance");
    // A result beat ends the busy period
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("busy held after result");
    // Empty flag agrees with count
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (is_empty == (item_count == 11'd0)))
        else $error("empty flag wrong");
`endif

endmodule
